// ===== sv/ipsc_pkg.sv =====
// Shared types and constants of the incremental PI speed controller.
`default_nettype none

package ipsc_pkg;

   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SPEED  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_BIAS = 8'd3;

   localparam logic [6:0]  ERR_CLAMP   = 7'd100;
   localparam logic [6:0]  SMALL_ERR   = 7'd2;
   localparam logic [7:0]  DIV_BASE    = 8'd200;
   // floor(2^24 / 200); quotient estimate is low by at most one
   localparam logic [16:0] DIV_RECIP   = 17'd83886;

   typedef struct packed {
      logic signed [15:0] position_error;
      logic signed [15:0] measured_speed;
      logic signed [15:0] straight_speed;
   } ipsc_req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic signed [15:0] target_speed;
   } ipsc_rsp_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic corr;
      logic tgt;
      logic err;
      logic mul3;
      logic acc;
      logic out;
   } ipsc_cmd_type;

   typedef struct packed {
      logic out_free;
   } ipsc_sts_type;

endpackage

`default_nettype wire

// ===== sv/ipsc_ctrl.sv =====
// Step sequencer of the speed controller.
`default_nettype none

module ipsc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  ipsc_pkg::ipsc_sts_type sts,
   output ipsc_pkg::ipsc_cmd_type cmd
);
   import ipsc_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL1 = 4'd1;
   localparam logic [3:0] ST_MUL2 = 4'd2;
   localparam logic [3:0] ST_CORR = 4'd3;
   localparam logic [3:0] ST_TGT  = 4'd4;
   localparam logic [3:0] ST_ERR  = 4'd5;
   localparam logic [3:0] ST_MUL3 = 4'd6;
   localparam logic [3:0] ST_ACC  = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_CORR;
         end
         ST_CORR: begin
            cmd.corr = 1'b1;
            state_in = ST_TGT;
         end
         ST_TGT: begin
            cmd.tgt  = 1'b1;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ipsc_dp.sv =====
// Datapath of the speed controller: target shaping, PI update and result word.
`default_nettype none

module ipsc_dp #(
   parameter int FRAC_BITS = 8
) (
   input  wire                            clock,
   input  wire                            reset,
   input  ipsc_pkg::ipsc_cmd_type         cmd,
   output ipsc_pkg::ipsc_sts_type         sts,
   input  ipsc_pkg::ipsc_req_type         req_data,
   input  wire                            csr_valid,
   input  wire [ipsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [15:0]                     csr_data,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output ipsc_pkg::ipsc_rsp_type         rsp_data
);
   import ipsc_pkg::*;

   // configuration
   logic        [15:0] prop_gain_ff;
   logic        [15:0] integ_gain_ff;
   logic signed [15:0] min_speed_ff;
   logic signed [15:0] speed_bias_ff;

   // controller state
   logic signed [15:0] last_error_ff, last_error_in;
   logic signed [31:0] acc_ff, acc_in;

   // step registers
   logic               small_ff, small_in;
   logic        [7:0]  fac_ff, fac_in;
   logic signed [16:0] span_ff, span_in;
   logic signed [15:0] meas_ff, straight_ff;
   logic signed [24:0] prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic        [23:0] mag_ff, mag_in;
   logic        [15:0] q0_ff, q0_in;
   logic signed [16:0] quot_ff, quot_in;
   logic signed [15:0] target_ff, target_in;
   logic signed [15:0] err_ff, err_in;
   logic signed [16:0] diff_ff, diff_in;
   logic signed [32:0] p1_ff, p1_in;
   logic signed [32:0] p2_ff, p2_in;
   logic               rsp_valid_ff;
   ipsc_rsp_type       rsp_data_ff, rsp_data_in;

   logic signed [16:0] pos_ext;
   logic        [16:0] abs_val;
   logic        [6:0]  a_clamp;
   logic signed [25:0] m1_a, m1_b, m1_p;
   logic        [40:0] m2_p;
   logic        [23:0] prod200, rem;
   logic        [16:0] q_fix;
   logic signed [17:0] base;
   logic signed [18:0] tsum;
   logic signed [16:0] esum;
   logic signed [33:0] m3_p1;
   logic signed [32:0] m3_p2;
   logic signed [34:0] nsum;
   logic signed [32:0] acc_rnd;
   logic signed [32:0] whole;

   // load: clamp error and set up the span
   always_comb begin
      pos_ext  = {req_data.position_error[15], req_data.position_error};
      abs_val  = pos_ext[16] ? 17'(-pos_ext) : 17'(pos_ext);
      a_clamp  = (abs_val > {10'd0, ERR_CLAMP}) ? ERR_CLAMP : abs_val[6:0];
      small_in = (a_clamp <= SMALL_ERR);
      fac_in   = DIV_BASE - {1'b0, a_clamp};
      span_in  = {req_data.straight_speed[15], req_data.straight_speed}
               - {min_speed_ff[15], min_speed_ff};
   end

   // span * (200 - a)
   always_comb begin
      m1_a    = {{9{span_ff[16]}}, span_ff};
      m1_b    = $signed({18'd0, fac_ff});
      m1_p    = m1_a * m1_b;
      prod_in = m1_p[24:0];
   end

   // magnitude and reciprocal estimate of the quotient by 200
   always_comb begin
      neg_in = prod_ff[24];
      mag_in = prod_ff[24] ? 24'(-prod_ff) : prod_ff[23:0];
      m2_p   = {17'd0, mag_in} * {24'd0, DIV_RECIP};
      q0_in  = m2_p[39:24];
   end

   // one-step correction and sign restore
   always_comb begin
      prod200 = {8'd0, q0_ff} * {16'd0, DIV_BASE};
      rem     = mag_ff - prod200;
      q_fix   = {1'b0, q0_ff} + {16'd0, (rem >= {16'd0, DIV_BASE})};
      quot_in = neg_ff ? -$signed(q_fix) : $signed(q_fix);
   end

   // target with bias, saturated
   always_comb begin
      base = small_ff ? {{2{straight_ff[15]}}, straight_ff}
                      : {{2{min_speed_ff[15]}}, min_speed_ff} + {quot_ff[16], quot_ff};
      tsum = {base[17], base} + {{3{speed_bias_ff[15]}}, speed_bias_ff};
      if (tsum > 19'sd32767) begin
         target_in = 16'sh7FFF;
      end else if (tsum < -19'sd32768) begin
         target_in = 16'sh8000;
      end else begin
         target_in = tsum[15:0];
      end
   end

   // speed error, saturated, and its change
   always_comb begin
      esum = {target_ff[15], target_ff} - {meas_ff[15], meas_ff};
      if (esum > 17'sd32767) begin
         err_in = 16'sh7FFF;
      end else if (esum < -17'sd32768) begin
         err_in = 16'sh8000;
      end else begin
         err_in = esum[15:0];
      end
      diff_in = {err_in[15], err_in} - {last_error_ff[15], last_error_ff};
   end

   // gain products
   always_comb begin
      m3_p1 = $signed({{17{diff_ff[16]}}, diff_ff}) * $signed({18'd0, prop_gain_ff});
      m3_p2 = $signed({{17{err_ff[15]}}, err_ff}) * $signed({17'd0, integ_gain_ff});
      p1_in = m3_p1[32:0];
      p2_in = m3_p2;
   end

   // accumulate with saturation
   always_comb begin
      nsum = {{3{acc_ff[31]}}, acc_ff} + {{2{p1_ff[32]}}, p1_ff}
           + {{2{p2_ff[32]}}, p2_ff};
      if (nsum > 35'sh0_7FFF_FFFF) begin
         acc_in = 32'sh7FFF_FFFF;
      end else if (nsum < -35'sh0_8000_0000) begin
         acc_in = 32'sh8000_0000;
      end else begin
         acc_in = nsum[31:0];
      end
      last_error_in = err_ff;
   end

   // integer part toward zero, saturated
   always_comb begin
      acc_rnd = {acc_ff[31], acc_ff}
              + $signed({{(33-FRAC_BITS){1'b0}}, {FRAC_BITS{acc_ff[31]}}});
      whole   = acc_rnd >>> FRAC_BITS;
      if (whole > 33'sd32767) begin
         rsp_data_in.drive = 16'sh7FFF;
      end else if (whole < -33'sd32768) begin
         rsp_data_in.drive = 16'sh8000;
      end else begin
         rsp_data_in.drive = whole[15:0];
      end
      rsp_data_in.target_speed = target_ff;
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         min_speed_ff  <= '0;
         speed_bias_ff <= '0;
         last_error_ff <= '0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_PROP_GAIN:  prop_gain_ff  <= csr_data;
               REG_INTEG_GAIN: integ_gain_ff <= csr_data;
               REG_MIN_SPEED:  min_speed_ff  <= $signed(csr_data);
               REG_SPEED_BIAS: speed_bias_ff <= $signed(csr_data);
               default: ;
            endcase
         end
         if (cmd.acc) begin
            acc_ff        <= acc_in;
            last_error_ff <= last_error_in;
         end
         if (cmd.out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         small_ff    <= small_in;
         fac_ff      <= fac_in;
         span_ff     <= span_in;
         meas_ff     <= req_data.measured_speed;
         straight_ff <= req_data.straight_speed;
      end
      if (cmd.mul1) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul2) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
         q0_ff  <= q0_in;
      end
      if (cmd.corr) begin
         quot_ff <= quot_in;
      end
      if (cmd.tgt) begin
         target_ff <= target_in;
      end
      if (cmd.err) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
      end
      if (cmd.mul3) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (cmd.out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/incremental_pi_speed_control_top.sv =====
// Top level of the incremental PI wheel speed controller.
// A word accepted in idle runs through the nine-step sequencer and its three
// multiply steps before its result shows on rsp_; no new word is taken until
// the result word is registered; a stalled result word holds the sequencer.
// Reset (synchronous, active high) clears the gains, min speed, bias,
// accumulator, last error and the result valid flag.
`default_nettype none

module incremental_pi_speed_control_top #(
   parameter int FRAC_BITS = 8
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  ipsc_pkg::ipsc_req_type        req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output ipsc_pkg::ipsc_rsp_type        rsp_data,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [ipsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [15:0]                    csr_data
);
   import ipsc_pkg::*;

   ipsc_cmd_type cmd;
   ipsc_sts_type sts;

   assign csr_ready = 1'b1;

   ipsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ipsc_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/ipsc_chk.sv =====
// Port-level checker for the speed controller, bound to the top level.
`default_nettype none

module ipsc_chk (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input ipsc_pkg::ipsc_rsp_type rsp_data,
   input wire                    rsp_valid,
   input wire                    rsp_stall
);
   import ipsc_pkg::*;

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("input not stalled while a word is in work");

   a_busy_through_steps: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ##8 req_stall)
      else $error("word finished before its last step");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a word in work");

endmodule

bind incremental_pi_speed_control_top ipsc_chk u_ipsc_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

`default_nettype wire

// ===== tb/incremental_pi_speed_control_top_tb.sv =====
// Self-checking testbench for the incremental PI wheel speed controller.
`default_nettype none

module incremental_pi_speed_control_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ipsc_pkg::*;

   localparam int FRAC_BITS  = 8;
   localparam int SETTLE     = 20;
   localparam int LONG_HOLD  = 150;
   localparam int PHASES     = 6;
   localparam int PHASE_LEN  = 158;
   localparam int DIR_COUNT  = 22;

   typedef struct packed {
      logic [1:0]         setting;
      logic signed [15:0] pos;
      logic signed [15:0] meas;
      logic signed [15:0] straight;
      logic               typed;
      logic signed [15:0] drive;
      logic signed [15:0] tgt;
   } dir_row_type;

   // setting 0 is the reset state; expected words typed in only there
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{2'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
      '{2'd0, 16'sd2, 16'sh8000, 16'sd32767, 1'b1, 16'sd0, 16'sd32767},
      '{2'd0, -16'sd2, 16'sd32767, 16'sh8000, 1'b1, 16'sd0, 16'sh8000},
      '{2'd0, 16'sd3, 16'sd0, 16'sd200, 1'b1, 16'sd0, 16'sd197},
      '{2'd0, 16'sd100, 16'sd0, 16'sd1000, 1'b1, 16'sd0, 16'sd500},
      '{2'd0, 16'sd32767, 16'sd0, -16'sd1000, 1'b1, 16'sd0, -16'sd500},
      '{2'd0, 16'sh8000, 16'sd0, 16'sd32767, 1'b1, 16'sd0, 16'sd16383},
      '{2'd0, 16'sh8000, 16'sd0, 16'sh8000, 1'b1, 16'sd0, -16'sd16384},
      '{2'd0, 16'sd101, 16'sd0, 16'sd201, 1'b1, 16'sd0, 16'sd100},
      '{2'd0, -16'sd101, 16'sd0, -16'sd201, 1'b1, 16'sd0, -16'sd100},
      '{2'd1, 16'sd0, 16'sd100, 16'sd1000, 1'b0, 16'sd0, 16'sd0},
      '{2'd1, 16'sd50, 16'sh8000, 16'sd1000, 1'b0, 16'sd0, 16'sd0},
      '{2'd1, -16'sd50, 16'sd32767, -16'sd1000, 1'b0, 16'sd0, 16'sd0},
      '{2'd1, 16'sd3, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{2'd1, -16'sd100, 16'sd0, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
      '{2'd1, 16'sd1, 16'sd1, 16'sd1, 1'b0, 16'sd0, 16'sd0},
      '{2'd2, 16'sd0, 16'sh8000, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
      '{2'd2, 16'sd100, 16'sd32767, 16'sh8000, 1'b0, 16'sd0, 16'sd0},
      '{2'd2, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{2'd3, -16'sd2, 16'sd32767, 16'sh8000, 1'b0, 16'sd0, 16'sd0},
      '{2'd3, 16'sd50, 16'sh8000, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
      '{2'd3, 16'sd77, 16'sd12345, -16'sd12345, 1'b0, 16'sd0, 16'sd0}
   };

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_stall;
   ipsc_req_type         req_data   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall  = 1'b0;
   ipsc_rsp_type         rsp_data;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [15:0]          csr_data   = '0;

   // controller state as predicted
   int kp_q       = 0;
   int ki_q       = 0;
   int min_q      = 0;
   int bias_q     = 0;
   int last_err_q = 0;
   int acc_q      = 0;

   ipsc_rsp_type pending_drive_q [$];
   ipsc_rsp_type want;
   int  fails         = 0;
   bit  req_quiet     = 1'b0;
   bit  rsp_quiet     = 1'b0;
   bit  hold_request  = 1'b0;

   incremental_pi_speed_control_top #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic ipsc_rsp_type pi_step(input ipsc_req_type w);
      longint mag, base, tgt, err, inc, acc, whole;
      ipsc_rsp_type r;
      mag = w.position_error;
      if (mag < 0) mag = -mag;
      if (mag > 100) mag = 100;
      if (mag <= 2) begin
         base = w.straight_speed;
      end else begin
         base = min_q + ((longint'(w.straight_speed) - min_q) * (200 - mag)) / 200;
      end
      tgt = clip(base + bias_q, -32768, 32767);
      err = clip(tgt - w.measured_speed, -32768, 32767);
      inc = longint'(kp_q) * (err - last_err_q) + longint'(ki_q) * err;
      acc = clip(acc_q + inc, -64'sd2147483648, 64'sd2147483647);
      acc_q = int'(acc);
      last_err_q = int'(err);
      whole = clip(acc / (64'sd1 <<< FRAC_BITS), -32768, 32767);
      r.drive = 16'(whole);
      r.target_speed = 16'(tgt);
      return r;
   endfunction

   function automatic int gap_len(input bit quiet);
      if (quiet || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(0, 600));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2, 3: return 16'($urandom_range(0, 2000) - 1000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic ipsc_req_type random_word();
      ipsc_req_type w;
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) w.position_error = 16'($urandom_range(0, 240) - 120);
      else if (r < 8) w.position_error = 16'($urandom_range(0, 6) - 3);
      else w.position_error = 16'($urandom);
      w.measured_speed = $urandom_range(0, 1) ? 16'($urandom)
                                             : 16'($urandom_range(0, 4000) - 2000);
      w.straight_speed = $urandom_range(0, 1) ? 16'($urandom)
                                             : 16'($urandom_range(0, 4000) - 2000);
      return w;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_PROP_GAIN:  kp_q = int'(v);
         REG_INTEG_GAIN: ki_q = int'(v);
         REG_MIN_SPEED:  min_q = int'(signed'(v));
         REG_SPEED_BIAS: bias_q = int'(signed'(v));
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [15:0] kp, ki, mn, bs);
      write_reg(REG_PROP_GAIN, kp);
      write_reg(REG_INTEG_GAIN, ki);
      write_reg(REG_MIN_SPEED, mn);
      write_reg(REG_SPEED_BIAS, bs);
      // unmapped index, must leave every register alone
      write_reg(CSR_IDX_W'($urandom_range(4, 255)), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input int k);
      case (k)
         0: set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
         1: set_regs(16'h0180, 16'h0040, 16'($signed(-500)), 16'd300);
         2: set_regs(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
         default: set_regs(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000);
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_word(input ipsc_req_type w, input bit typed, input ipsc_rsp_type typed_rsp);
      ipsc_rsp_type p;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = pi_step(w);
      pending_drive_q.push_back(typed ? typed_rsp : p);
   endtask

   task automatic idle_gap();
      int n;
      n = gap_len(req_quiet);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // result side: random stall runs, one long hold on request
   initial begin
      int  n;
      bit  v;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            v = 1'b1;
            n = LONG_HOLD;
         end else if (rsp_quiet || $urandom_range(0, 2) != 0) begin
            v = 1'b0;
            n = $urandom_range(1, 4);
         end else begin
            v = 1'b1;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         end
         rsp_stall <= v;
         repeat (n - 1) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drive_q.size() == 0) begin
            fails++;
            if (fails <= 10)
               $display("unexpected word: drive %0d target %0d",
                        rsp_data.drive, rsp_data.target_speed);
         end else begin
            want = pending_drive_q.pop_front();
            if (rsp_data.drive !== want.drive ||
                rsp_data.target_speed !== want.target_speed) begin
               fails++;
               if (fails <= 10)
                  $display("word mismatch: drive exp %0d got %0d, target exp %0d got %0d",
                           want.drive, rsp_data.drive,
                           want.target_speed, rsp_data.target_speed);
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      ipsc_req_type w;
      ipsc_rsp_type typed_rsp;
      int cur;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur = -1;
      for (int i = 0; i < DIR_COUNT; i++) begin
         if (int'(DIR_ROWS[i].setting) != cur) begin
            drain();
            cur = int'(DIR_ROWS[i].setting);
            apply_setting(cur);
         end
         w.position_error = DIR_ROWS[i].pos;
         w.measured_speed = DIR_ROWS[i].meas;
         w.straight_speed = DIR_ROWS[i].straight;
         typed_rsp.drive = DIR_ROWS[i].drive;
         typed_rsp.target_speed = DIR_ROWS[i].tgt;
         send_word(w, DIR_ROWS[i].typed, typed_rsp);
         idle_gap();
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            1: set_regs(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
            5: set_regs(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000);
            default: set_regs(pick_gain(), pick_gain(), pick_speed(), pick_speed());
         endcase
         req_quiet = (p == 2 || p == 4);
         rsp_quiet = (p == 4);
         for (int k = 0; k < PHASE_LEN; k++) begin
            // long result hold while words keep coming
            if (p == 2 && k == 5) hold_request = 1'b1;
            if (p == 3 && k == PHASE_LEN / 2) drain();
            send_word(random_word(), 1'b0, typed_rsp);
            idle_gap();
         end
      end

      drain();
      fails += pending_drive_q.size();
      if (fails == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
